// File: design/stw_pkg.sv
// ---------------------------------------------------------------------------
// stw_pkg: shared types and constants of the smoothstep tween handle table
// Holds the opcodes, the controller states, the command and status structs
// that join the controller to the datapath, and the fixed-point constants.
// ---------------------------------------------------------------------------
package stw_pkg;

  localparam int ID_W     = 9;
  localparam int DATA_W   = 32;
  localparam int CHUNK_W  = 16;  // slots examined per cycle by the free-slot scan
  localparam int CHUNK_AW = 4;
  localparam int GEO_W    = 5 * DATA_W;

  localparam logic [DATA_W-1:0] ONE_Q16   = 32'h0001_0000;
  localparam logic [16:0]       ONE_FRAC  = 17'h1_0000;
  localparam logic [17:0]       THREE_Q16 = 18'h3_0000;

  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_STEP    = 3'd1,
    OP_GET     = 3'd2,
    OP_RESET   = 3'd3,
    OP_DESTROY = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_ALLOC,
    ST_READ,
    ST_DIV,
    ST_SQ,
    ST_EASE,
    ST_LERP_X,
    ST_LERP_Y,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic alloc;
    logic destroy;
    logic set_found;
    logic step_wr;
    logic reset_wr;
    logic div_load;
    logic div_step;
    logic sq;
    logic ease;
    logic lerp_x;
    logic lerp_y;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       hit;
    logic       scan_hit;
    logic       scan_last;
    logic       div_last;
    logic       out_free;
  } stat_t;

endpackage

// File: design/stw_if.sv
// ---------------------------------------------------------------------------
// stw_if: command and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ---------------------------------------------------------------------------
interface stw_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic [8:0]         handle_id;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic [31:0]        span;
  logic [31:0]        time_delta;

  modport source (output valid, opcode, handle_id, start_x, start_y, end_x, end_y,
                  span, time_delta, input ready);
  modport sink (input valid, opcode, handle_id, start_x, start_y, end_x, end_y,
                span, time_delta, output ready);
endinterface

interface stw_out_if;
  logic               valid;
  logic               ready;
  logic [8:0]         new_id;
  logic               found;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;

  modport source (output valid, new_id, found, pos_x, pos_y, input ready);
  modport sink (input valid, new_id, found, pos_x, pos_y, output ready);
endinterface

// File: design/smoothstep_tween_handle_table.sv
// ---------------------------------------------------------------------------
// smoothstep_tween_handle_table: table of smoothstep tweens
// Create, step, get, reset and destroy commands on a table of tween slots,
// one result beat per command beat.
// ---------------------------------------------------------------------------
//
//   channel   direction  handshake          payload
//   in_ch     input      valid / ready      opcode, handle_id, start/end x/y,
//                                           span, time_delta
//   out_ch    output     valid / ready      new_id, found, pos_x, pos_y
//
// Sequencing: one command at a time. Destroy, reset and rejected commands go
// from decode to the result; step writes the elapsed time, capped at span;
// create scans the active bits 16 slots at a time; get runs the restoring
// divider for elapsed/duration and four passes through the one multiplier.
// Reset clears the controller, the active bits and the output valid; the
// slot RAMs are not cleared and are read only for active slots.
// Stalls: a finished result waits in the output register while the next
// command beat is accepted; only the final hand-off waits for out_ch.ready.
// ---------------------------------------------------------------------------
module smoothstep_tween_handle_table #(
  parameter int NUM_HANDLES = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  stw_in_if.sink    in_ch,
  stw_out_if.source out_ch
);

  stw_pkg::cmd_t  cmd;
  stw_pkg::stat_t stat;
  logic           ready;

  // Sequencer: decides what the datapath does in each cycle.
  stw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  assign in_ch.ready = ready;

  // Datapath: storage, arithmetic and the output register.
  stw_dp #(.NUM_HANDLES(NUM_HANDLES)) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule

// File: design/stw_ram.sv
// ---------------------------------------------------------------------------
// stw_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module stw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/stw_ctrl.sv
// ---------------------------------------------------------------------------
// stw_ctrl: command sequencer
// Walks one command through decode, slot scan, table access, the fraction
// divider and the easing multiplies, then hands the result to the output.
// ---------------------------------------------------------------------------
module stw_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  stw_pkg::stat_t stat,
  output stw_pkg::cmd_t  cmd
);

  stw_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stw_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      stw_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = stw_pkg::ST_DECODE;
        end
      end
      stw_pkg::ST_DECODE: begin
        if (stat.op == stw_pkg::OP_CREATE) begin
          state_nxt = stw_pkg::ST_SCAN;
        end else if (stat.op == stw_pkg::OP_DESTROY) begin
          cmd.destroy = 1'b1;
          state_nxt   = stw_pkg::ST_DONE;
        end else if (stat.hit && stat.op == stw_pkg::OP_RESET) begin
          cmd.set_found = 1'b1;
          cmd.reset_wr  = 1'b1;
          state_nxt     = stw_pkg::ST_DONE;
        end else if (stat.hit && (stat.op == stw_pkg::OP_STEP ||
                                  stat.op == stw_pkg::OP_GET)) begin
          cmd.set_found = 1'b1;
          state_nxt     = stw_pkg::ST_READ;
        end else begin
          state_nxt = stw_pkg::ST_DONE;
        end
      end
      stw_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_hit) begin
          state_nxt = stw_pkg::ST_ALLOC;
        end else if (stat.scan_last) begin
          state_nxt = stw_pkg::ST_DONE;
        end
      end
      stw_pkg::ST_ALLOC: begin
        cmd.alloc = 1'b1;
        state_nxt = stw_pkg::ST_DONE;
      end
      stw_pkg::ST_READ: begin
        if (stat.op == stw_pkg::OP_STEP) begin
          cmd.step_wr = 1'b1;
          state_nxt   = stw_pkg::ST_DONE;
        end else begin
          cmd.div_load = 1'b1;
          state_nxt    = stw_pkg::ST_DIV;
        end
      end
      stw_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = stw_pkg::ST_SQ;
        end
      end
      stw_pkg::ST_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = stw_pkg::ST_EASE;
      end
      stw_pkg::ST_EASE: begin
        cmd.ease  = 1'b1;
        state_nxt = stw_pkg::ST_LERP_X;
      end
      stw_pkg::ST_LERP_X: begin
        cmd.lerp_x = 1'b1;
        state_nxt  = stw_pkg::ST_LERP_Y;
      end
      stw_pkg::ST_LERP_Y: begin
        cmd.lerp_y = 1'b1;
        state_nxt  = stw_pkg::ST_DONE;
      end
      stw_pkg::ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = stw_pkg::ST_IDLE;
        end
      end
      default: state_nxt = stw_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: design/stw_dp.sv
// ---------------------------------------------------------------------------
// stw_dp: tween table datapath
// Active bits, slot RAMs, free-slot scan, restoring fraction divider, one
// shared multiplier for the easing and interpolation, and the output register.
// ---------------------------------------------------------------------------
module stw_dp #(
  parameter int NUM_HANDLES = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  stw_in_if.sink         in_ch,
  stw_out_if.source      out_ch,
  input  stw_pkg::cmd_t  cmd,
  output stw_pkg::stat_t stat
);

  localparam int SLOT_W = (NUM_HANDLES > 1) ? $clog2(NUM_HANDLES) : 1;
  localparam int NCHUNK = (NUM_HANDLES + stw_pkg::CHUNK_W - 1) / stw_pkg::CHUNK_W;
  localparam int CH_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int PAD_W  = NCHUNK * stw_pkg::CHUNK_W;

  // Latched command.
  logic [2:0]  op_r;
  logic [8:0]  id_r;
  logic [31:0] sx_in_r, sy_in_r, ex_in_r, ey_in_r, span_in_r, dt_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_ch.opcode;
      id_r      <= in_ch.handle_id;
      sx_in_r   <= in_ch.start_x;
      sy_in_r   <= in_ch.start_y;
      ex_in_r   <= in_ch.end_x;
      ey_in_r   <= in_ch.end_y;
      span_in_r <= in_ch.span;
      dt_r      <= in_ch.time_delta;
    end
  end

  logic              id_ok;
  logic [SLOT_W-1:0] slot;
  logic [NUM_HANDLES-1:0] active_r;
  logic              hit;

  assign id_ok = (id_r != 9'd0) && (int'(id_r) <= NUM_HANDLES);
  assign slot  = SLOT_W'({{SLOT_W{1'b0}}, id_r} - 1'b1);
  assign hit   = id_ok && active_r[slot];

  // Free-slot scan, one chunk of slots per cycle; slots past the end read busy.
  logic [CH_W-1:0]             chunk_r;
  logic [PAD_W-1:0]            busy_pad;
  logic [stw_pkg::CHUNK_W-1:0] free_bits;
  logic [stw_pkg::CHUNK_AW-1:0] free_pos;
  logic                        scan_hit;
  logic [SLOT_W-1:0]           alloc_slot_r;

  always_comb begin
    busy_pad                    = '1;
    busy_pad[NUM_HANDLES-1:0]   = active_r;
    free_bits = ~busy_pad[chunk_r*stw_pkg::CHUNK_W +: stw_pkg::CHUNK_W];
    free_pos  = '0;
    for (int i = stw_pkg::CHUNK_W - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        free_pos = stw_pkg::CHUNK_AW'(i);
      end
    end
  end

  assign scan_hit = |free_bits;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      chunk_r <= '0;
    end else if (cmd.scan_step) begin
      if (scan_hit) begin
        alloc_slot_r <= SLOT_W'({chunk_r, free_pos});
      end else begin
        chunk_r <= chunk_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else begin
      if (cmd.alloc) begin
        active_r[alloc_slot_r] <= 1'b1;
      end
      if (cmd.destroy && id_ok) begin
        active_r[slot] <= 1'b0;
      end
    end
  end

  // Slot storage.
  logic [stw_pkg::GEO_W-1:0]  geo_rd;
  logic [31:0]                el_rd;
  logic [31:0]                span_fix;
  logic [31:0]                sx_rd, sy_rd, ex_rd, ey_rd, sp_rd;
  logic [32:0]                step_sum;
  logic [31:0]                step_sat;
  logic                       el_we;
  logic [SLOT_W-1:0]          el_waddr;
  logic [31:0]                el_wdata;

  assign span_fix = (span_in_r == 32'd0) ? stw_pkg::ONE_Q16 : span_in_r;

  stw_ram #(.WIDTH(stw_pkg::GEO_W), .DEPTH(NUM_HANDLES)) u_geo_ram (
    .clk   (clk),
    .we    (cmd.alloc),
    .waddr (alloc_slot_r),
    .wdata ({sx_in_r, sy_in_r, ex_in_r, ey_in_r, span_fix}),
    .raddr (slot),
    .rdata (geo_rd)
  );

  assign sx_rd = geo_rd[159:128];
  assign sy_rd = geo_rd[127:96];
  assign ex_rd = geo_rd[95:64];
  assign ey_rd = geo_rd[63:32];
  assign sp_rd = geo_rd[31:0];

  assign step_sum = {1'b0, el_rd} + {1'b0, dt_r};
  assign step_sat = (step_sum >= {1'b0, sp_rd}) ? sp_rd : step_sum[31:0];
  assign el_we    = cmd.alloc || cmd.step_wr || cmd.reset_wr;
  assign el_waddr = cmd.alloc ? alloc_slot_r : slot;
  assign el_wdata = cmd.step_wr ? step_sat : 32'd0;

  stw_ram #(.WIDTH(stw_pkg::DATA_W), .DEPTH(NUM_HANDLES)) u_el_ram (
    .clk   (clk),
    .we    (el_we),
    .waddr (el_waddr),
    .wdata (el_wdata),
    .raddr (slot),
    .rdata (el_rd)
  );

  // Restoring divider: one quotient bit per cycle. The remainder stays below span
  // unless the tween has run out, in which case the quotient is not used.
  logic [31:0]        rem_r;
  logic [15:0]        q_r;
  logic               full_r;
  logic [3:0]         cnt_r;
  logic signed [32:0] dx_r, dy_r;
  logic [32:0]        rem_shl;
  logic               rem_ge;
  logic [16:0]        frac;

  assign rem_shl = {rem_r, 1'b0};
  assign rem_ge  = rem_shl >= {1'b0, sp_rd};
  assign frac    = full_r ? stw_pkg::ONE_FRAC : {1'b0, q_r};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r  <= el_rd;
      q_r    <= '0;
      full_r <= el_rd >= sp_rd;
      cnt_r  <= '0;
      dx_r   <= $signed({ex_rd[31], ex_rd}) - $signed({sx_rd[31], sx_rd});
      dy_r   <= $signed({ey_rd[31], ey_rd}) - $signed({sy_rd[31], sy_rd});
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? 32'(rem_shl - {1'b0, sp_rd}) : rem_shl[31:0];
      q_r   <= {q_r[14:0], rem_ge};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Shared multiplier: f*f, then (f*f)*(3 - 2f), then d*s for x and y.
  logic signed [34:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [53:0] prod;
  logic [17:0]        ease_k;
  logic [33:0]        ff_r;
  logic [16:0]        s_r;

  assign ease_k = stw_pkg::THREE_Q16 - {frac, 1'b0};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    priority if (cmd.sq) begin
      mul_a = $signed({18'd0, frac});
      mul_b = $signed({2'd0, frac});
    end else if (cmd.ease) begin
      mul_a = $signed({1'b0, ff_r});
      mul_b = $signed({1'b0, ease_k});
    end else if (cmd.lerp_x) begin
      mul_a = {{2{dx_r[32]}}, dx_r};
      mul_b = $signed({2'd0, s_r});
    end else if (cmd.lerp_y) begin
      mul_a = {{2{dy_r[32]}}, dy_r};
      mul_b = $signed({2'd0, s_r});
    end
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.sq) begin
      ff_r <= prod[33:0];
    end
    if (cmd.ease) begin
      s_r <= prod[48:32];
    end
  end

  // Result being assembled.
  logic [8:0]  new_id_r;
  logic        found_r;
  logic [31:0] px_r, py_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      new_id_r <= '0;
      found_r  <= 1'b0;
      px_r     <= '0;
      py_r     <= '0;
    end else begin
      if (cmd.alloc) begin
        new_id_r <= 9'({1'b0, alloc_slot_r} + 1'b1);
        found_r  <= 1'b1;
      end
      if (cmd.set_found) begin
        found_r <= 1'b1;
      end
      if (cmd.destroy) begin
        found_r <= hit;
      end
      if (cmd.lerp_x) begin
        px_r <= sx_rd + prod[47:16];
      end
      if (cmd.lerp_y) begin
        py_r <= sy_rd + prod[47:16];
      end
    end
  end

  // Output register.
  logic        out_valid_r;
  logic [8:0]  o_new_id_r;
  logic        o_found_r;
  logic [31:0] o_px_r, o_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_new_id_r <= new_id_r;
      o_found_r  <= found_r;
      o_px_r     <= px_r;
      o_py_r     <= py_r;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.new_id = o_new_id_r;
  assign out_ch.found  = o_found_r;
  assign out_ch.pos_x  = o_px_r;
  assign out_ch.pos_y  = o_py_r;

  assign stat.op        = op_r;
  assign stat.hit       = hit;
  assign stat.scan_hit  = scan_hit;
  assign stat.scan_last = chunk_r == CH_W'(NCHUNK - 1);
  assign stat.div_last  = cnt_r == 4'd15;
  assign stat.out_free  = !out_valid_r || out_ch.ready;

  a_alloc_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc |-> !active_r[alloc_slot_r])
    else $error("allocation targets a busy slot");

  a_alloc_sets: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc |=> active_r[$past(alloc_slot_r)])
    else $error("allocated slot not marked active");

  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && !full_r) |-> rem_r < sp_rd)
    else $error("divider remainder not below span");

  a_ease_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ease |=> s_r <= stw_pkg::ONE_FRAC)
    else $error("eased fraction above one");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ch.ready))
    else $error("result register overwritten while held");

endmodule
